FILE: rtl/core/vector_pair_set_table_core_macros.svh
`ifndef VECTOR_PAIR_SET_TABLE_CORE_MACROS_SVH
`define VECTOR_PAIR_SET_TABLE_CORE_MACROS_SVH
// Assertion wrappers: checked in simulation, empty for synthesis.
`ifndef SYNTHESIS
`define VPST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VPST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VPST_ASSERT(lbl, clk, rst_n, prop, msg)
`define VPST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/vpst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vpst_pkg;

	localparam int CAPACITY_DEF        = 64;
	localparam int COMPONENT_WIDTH_DEF = 32;
	localparam int FIELD_W             = 32;
	localparam int OP_W                = 2;
	localparam int STATUS_W            = 2;
	localparam int SLOT_W              = 6;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_RESULT
	} state_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic              is_full;
		logic              is_empty;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/core/vpst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module vpst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/vpst_engine.sv
`timescale 1ns / 1ps
`default_nettype none
`include "vector_pair_set_table_core_macros.svh"
module vpst_engine #(
	parameter int CAPACITY        = vpst_pkg::CAPACITY_DEF,
	parameter int COMPONENT_WIDTH = vpst_pkg::COMPONENT_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire vpst_pkg::op_t              req_op,
	input  wire logic [COMPONENT_WIDTH-1:0] req_x,
	input  wire logic [COMPONENT_WIDTH-1:0] req_y,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output vpst_pkg::result_t               res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = 2 * COMPONENT_WIDTH;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	vpst_pkg::state_t  state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     ptr_q, ptr_d;
	logic [AW-1:0]     hit_q, hit_d;
	vpst_pkg::op_t     op_q;
	logic [DW-1:0]     key_q;
	vpst_pkg::result_t res_q, res_d;
	logic              res_load;
	vpst_pkg::status_t st;
	logic [vpst_pkg::SLOT_W-1:0] sl;

	logic              chk_valid_s1;
	logic [AW-1:0]     chk_idx_s1;
	logic              match, chk_last, chk_is_last;
	logic [AW-1:0]     last_idx;

	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [DW-1:0]     rd_data, wr_data;

	function automatic logic [vpst_pkg::SLOT_W-1:0] to_slot(input logic [AW-1:0] idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[vpst_pkg::SLOT_W-1:0];
	endfunction

	vpst_ram #(
		.WIDTH (DW),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign last_idx    = AW'(count_q - ONE_C);
	assign match       = chk_valid_s1 && (rd_data == key_q);
	assign chk_is_last = (CW'(chk_idx_s1) == (count_q - ONE_C));
	assign chk_last    = chk_valid_s1 && chk_is_last;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		hit_d     = hit_q;
		res_d     = res_q;
		res_load  = 1'b0;
		st        = vpst_pkg::STAT_OK;
		sl        = '0;
		rd_en     = 1'b0;
		rd_addr   = ptr_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = count_q[AW-1:0];
		wr_data   = {req_x, req_y};
		req_ready = (state_q == vpst_pkg::ST_IDLE);
		res_valid = (state_q == vpst_pkg::ST_RESULT);

		unique case (state_q)
			vpst_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (req_op)
						vpst_pkg::OP_ADD: begin
							res_load = 1'b1;
							state_d  = vpst_pkg::ST_RESULT;
							if (count_q == CAP_C) begin
								st = vpst_pkg::STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + ONE_C;
								sl      = to_slot(count_q[AW-1:0]);
							end
						end
						vpst_pkg::OP_FIND, vpst_pkg::OP_REMOVE: begin
							if (count_q == '0) begin
								st       = vpst_pkg::STAT_NOT_FOUND;
								res_load = 1'b1;
								state_d  = vpst_pkg::ST_RESULT;
							end else begin
								ptr_d   = '0;
								state_d = vpst_pkg::ST_SCAN;
							end
						end
						vpst_pkg::OP_CLEAR: begin
							count_d  = '0;
							res_load = 1'b1;
							state_d  = vpst_pkg::ST_RESULT;
						end
						default: ;
					endcase
				end
			end
			vpst_pkg::ST_SCAN: begin
				// reads run one ahead of the compare
				rd_en = (ptr_q < count_q);
				if (rd_en) begin
					ptr_d = ptr_q + ONE_C;
				end
				if (match) begin
					if (op_q == vpst_pkg::OP_FIND || chk_is_last) begin
						if (op_q != vpst_pkg::OP_FIND) begin
							count_d = count_q - ONE_C;
						end
						sl       = to_slot(chk_idx_s1);
						res_load = 1'b1;
						state_d  = vpst_pkg::ST_RESULT;
					end else begin
						hit_d   = chk_idx_s1;
						state_d = vpst_pkg::ST_MOVE_RD;
					end
				end else if (chk_last) begin
					st       = vpst_pkg::STAT_NOT_FOUND;
					res_load = 1'b1;
					state_d  = vpst_pkg::ST_RESULT;
				end
			end
			vpst_pkg::ST_MOVE_RD: begin
				rd_en   = 1'b1;
				rd_addr = last_idx;
				state_d = vpst_pkg::ST_MOVE_WR;
			end
			vpst_pkg::ST_MOVE_WR: begin
				// last entry fills the hole
				wr_en    = 1'b1;
				wr_addr  = hit_q;
				wr_data  = rd_data;
				count_d  = count_q - ONE_C;
				sl       = to_slot(hit_q);
				res_load = 1'b1;
				state_d  = vpst_pkg::ST_RESULT;
			end
			vpst_pkg::ST_RESULT: begin
				if (res_ready) begin
					state_d = vpst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vpst_pkg::ST_IDLE;
			end
		endcase

		if (res_load) begin
			res_d.status   = st;
			res_d.slot     = sl;
			res_d.is_full  = (count_d == CAP_C);
			res_d.is_empty = (count_d == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vpst_pkg::ST_IDLE;
			count_q      <= '0;
			chk_valid_s1 <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			chk_valid_s1 <= rd_en && (state_q == vpst_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		ptr_q      <= ptr_d;
		hit_q      <= hit_d;
		res_q      <= res_d;
		chk_idx_s1 <= rd_addr;
		if (req_valid && req_ready) begin
			op_q  <= req_op;
			key_q <= {req_x, req_y};
		end
	end

	assign res = res_q;

	`VPST_ASSERT_ALWAYS(a_count_bound, clk, (!arst_n || (count_q <= CAP_C)), "entry count above capacity")
	`VPST_ASSERT(a_chk_in_range, clk, arst_n, (state_q == vpst_pkg::ST_SCAN && chk_valid_s1) |-> (CW'(chk_idx_s1) < count_q), "compared slot beyond count")
	`VPST_ASSERT(a_move_below_last, clk, arst_n, (state_q == vpst_pkg::ST_MOVE_WR) |-> (CW'(hit_q) < (count_q - ONE_C)), "move target not below last entry")
	`VPST_ASSERT(a_res_hold, clk, arst_n, (res_valid && !res_ready) |=> (res_valid && $stable(res_q)), "result changed before hand-off")

endmodule
`default_nettype wire

FILE: rtl/core/vector_pair_set_table_core.sv
// Table of up to CAPACITY (x, y) pairs, one request in, one result out.
// Input channel: in_valid / in_stall with opcode, x_value, y_value.
//   Opcodes: add, find, remove, clear. Only the low COMPONENT_WIDTH bits of
//   each component are stored and compared.
// Output channel: out_valid / out_stall with status, slot_index, is_full,
//   is_empty. Flags reflect the entry count after the request.
// Order of work, request accepted to result valid:
//   add, clear, or find/remove on an empty table: straight to the result, no scan
//   find: slots are read in order until one matches or the last entry is checked
//   remove: as find, plus a read and a write when the last entry has to be moved
// One request is in flight at a time: the next can be taken in the cycle
// after the previous result moves into the output register. The scan walks
// the single-read-port entry memory one slot per cycle.
// The output register lets a new request start while a result waits.
// If out_stall holds, the engine parks its next result and in_stall rises.
// Reset empties the table at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module vector_pair_set_table_core #(
	parameter int CAPACITY        = vpst_pkg::CAPACITY_DEF,
	parameter int COMPONENT_WIDTH = vpst_pkg::COMPONENT_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [vpst_pkg::OP_W-1:0]       opcode,
	input  wire logic signed [vpst_pkg::FIELD_W-1:0] x_value,
	input  wire logic signed [vpst_pkg::FIELD_W-1:0] y_value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [vpst_pkg::STATUS_W-1:0]        status,
	output logic [vpst_pkg::SLOT_W-1:0]          slot_index,
	output logic                                 is_full,
	output logic                                 is_empty
);

	logic              req_ready;
	logic              res_valid;
	logic              res_ready;
	vpst_pkg::result_t res;
	vpst_pkg::result_t out_q;
	logic              out_valid_q;

	vpst_engine #(
		.CAPACITY        (CAPACITY),
		.COMPONENT_WIDTH (COMPONENT_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (req_ready),
		.req_op    (vpst_pkg::op_t'(opcode)),
		.req_x     (x_value[COMPONENT_WIDTH-1:0]),
		.req_y     (y_value[COMPONENT_WIDTH-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign in_stall  = !req_ready;
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign slot_index = out_q.slot;
	assign is_full    = out_q.is_full;
	assign is_empty   = out_q.is_empty;

endmodule
`default_nettype wire
